/* src/cwb_pkg.sv */
// shared types and constants for the complex weighted beamformer
package cwb_pkg;

  localparam int unsigned SmpW = 16;
  localparam int unsigned AccW = 40;
  localparam int unsigned OutW = 48;

  typedef enum logic [2:0] {
    RegNumChan = 3'd0,
    RegNumPol  = 3'd1,
    RegNumAnt  = 3'd2,
    RegNumBeam = 3'd3,
    RegGainMan = 3'd4,
    RegGainSh  = 3'd5
  } reg_idx_e;

  typedef enum logic [0:0] {
    CmdWeight = 1'b0,
    CmdSample = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [0:0]  command;
    logic [3:0]  weight_chan;
    logic [0:0]  weight_pol;
    logic [3:0]  weight_ant;
    logic [2:0]  weight_beam;
    logic signed [15:0] weight_real;
    logic signed [15:0] weight_imag;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] beam_real;
    logic signed [47:0] beam_imag;
    logic [3:0] out_chan;
    logic [0:0] out_pol;
    logic [2:0] out_beam;
    logic [0:0] saturated;
    logic [0:0] last;
  } out_word_t;

  typedef struct packed {
    logic [2:0] index;
    logic [15:0] data;
  } cfg_word_t;

  // scale and clip one sum part
  function automatic logic [48:0] scale_sat(input logic signed [55:0] prod,
                                            input logic [4:0] sh);
    logic signed [55:0] r;
    logic sat;
    logic signed [47:0] o;
    r = prod >>> sh;
    sat = 1'b0;
    o = r[47:0];
    if (r > 56'sh007FFFFFFFFFFF) begin
      o = 48'sh7FFFFFFFFFFF;
      sat = 1'b1;
    end else if (r < -56'sh00800000000000) begin
      o = 48'sh800000000000;
      sat = 1'b1;
    end
    return {sat, o};
  endfunction

endpackage

/* src/cwb_if.sv */
// valid/ready stream interface
interface cwb_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/cwb_wmem.sv */
// weight memory, one write and one registered read port
module cwb_wmem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [31:0]      rdata_o
);
  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* src/cwb_accmem.sv */
// per-beam accumulator memory, read-modify-write
module cwb_accmem #(
  parameter int unsigned Beams = 8,
  parameter int unsigned BeamW = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [BeamW-1:0] waddr_i,
  input  logic [79:0]      wdata_i,
  input  logic [BeamW-1:0] raddr_i,
  output logic [79:0]      rdata_o
);
  logic [79:0] mem [Beams];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* src/complex_weighted_beamformer_unit.sv */
// beamformer top level: control, multiply-accumulate and scaling
// a weight word is taken while idle; a sample word makes one pass per beam,
// each beam going through weight read, multiply and accumulate write-back;
// a final antenna then emits one word per beam, each held until taken,
// each beam passing through accumulator read, gain multiply and present;
// the first antenna of a group masks the accumulator read, so no clear pass;
// reset clears counters and config registers, the weight memory is undefined until written
module complex_weighted_beamformer_unit
  import cwb_pkg::*;
#(
  parameter int unsigned MAX_CHAN = 16,
  parameter int unsigned MAX_POL  = 2,
  parameter int unsigned MAX_ANT  = 16,
  parameter int unsigned MAX_BEAM = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  cwb_if.sink   in_if,
  cwb_if.sink   cfg_if,
  cwb_if.source out_if
);
  localparam int unsigned ChW = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
  localparam int unsigned PoW = (MAX_POL > 1) ? $clog2(MAX_POL) : 1;
  localparam int unsigned AnW = (MAX_ANT > 1) ? $clog2(MAX_ANT) : 1;
  localparam int unsigned BmW = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;
  localparam int unsigned Depth = MAX_CHAN * MAX_POL * MAX_ANT * MAX_BEAM;
  localparam int unsigned AdW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StRd   = 7'b0000010,
    StMul  = 7'b0000100,
    StAcc  = 7'b0001000,
    StERd  = 7'b0010000,
    StEMul = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]  num_chan_q, num_ant_q;
  logic [1:0]  num_pol_q;
  logic [3:0]  num_beam_q;
  logic [15:0] gain_q;
  logic [4:0]  shift_q;
  logic [ChW-1:0] chan_q;
  logic [PoW-1:0] pol_q;
  logic [AnW-1:0] ant_q;
  logic [BmW-1:0] beam_q;
  logic first_q; // accumulators of this group start from zero
  logic signed [15:0] xr_q, xi_q;
  logic signed [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [55:0] gr_q, gi_q;
  logic [3:0] och_q;
  logic [0:0] opol_q;
  logic [2:0] obeam_q;
  logic       olast_q;

  // clamped geometry, widened to 11 bits
  logic [10:0] nc, np, na, nb;
  function automatic logic [10:0] clampv(input logic [4:0] v, input int unsigned hi);
    logic [10:0] r;
    r = {6'd0, v};
    if (v == 5'd0) r = 11'd1;
    else if (r > 11'(hi)) r = 11'(hi);
    return r;
  endfunction
  assign nc = clampv(num_chan_q, MAX_CHAN);
  assign np = clampv({3'd0, num_pol_q}, MAX_POL);
  assign na = clampv(num_ant_q, MAX_ANT);
  assign nb = clampv({1'b0, num_beam_q}, MAX_BEAM);

  logic last_beam, last_ant;
  assign last_beam = (11'(beam_q) + 11'd1 >= nb);
  assign last_ant  = (11'(ant_q) + 11'd1 >= na);

  // weight memory
  in_word_t iw;
  assign iw = in_if.data;
  logic w_ok, w_we;
  logic [AdW-1:0] waddr, raddr;
  logic [31:0] wrd;
  assign w_ok = (32'(iw.weight_chan) < MAX_CHAN) && (32'(iw.weight_pol) < MAX_POL)
             && (32'(iw.weight_ant) < MAX_ANT) && (32'(iw.weight_beam) < MAX_BEAM);
  assign w_we = in_if.valid && in_if.ready && (iw.command == CmdWeight) && w_ok;
  assign waddr = AdW'(((32'(iw.weight_chan) * MAX_POL + 32'(iw.weight_pol)) * MAX_ANT
               + 32'(iw.weight_ant)) * MAX_BEAM + 32'(iw.weight_beam));
  assign raddr = AdW'(((32'(chan_q) * MAX_POL + 32'(pol_q)) * MAX_ANT
               + 32'(ant_q)) * MAX_BEAM + 32'(beam_q));

  cwb_wmem #(.Depth(Depth), .AddrW(AdW)) u_wmem (
    .clk_i, .we_i(w_we), .waddr_i(waddr),
    .wdata_i({iw.weight_real, iw.weight_imag}),
    .raddr_i(raddr), .rdata_o(wrd)
  );

  // accumulator memory
  logic acc_we;
  logic [79:0] acc_wd, acc_rd;
  logic signed [39:0] ar, ai, nr, ni;
  assign ar = first_q ? '0 : acc_rd[79:40];
  assign ai = first_q ? '0 : acc_rd[39:0];
  assign nr = ar + 40'(p_rr_q) - 40'(p_ii_q);
  assign ni = ai + 40'(p_ri_q) + 40'(p_ir_q);
  assign acc_we = (state_q == StAcc);
  assign acc_wd = {nr, ni};

  cwb_accmem #(.Beams(MAX_BEAM), .BeamW(BmW)) u_acc (
    .clk_i, .we_i(acc_we), .waddr_i(beam_q), .wdata_i(acc_wd),
    .raddr_i(beam_q), .rdata_o(acc_rd)
  );

  assign in_if.ready  = (state_q == StIdle);
  assign cfg_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);

  logic [48:0] sr, si;
  assign sr = scale_sat(gr_q, shift_q);
  assign si = scale_sat(gi_q, shift_q);

  // scaled parts follow the registered gain products, stable while held
  assign out_if.data = '{beam_real: sr[47:0], beam_imag: si[47:0], out_chan: och_q,
                         out_pol: opol_q, out_beam: obeam_q,
                         saturated: sr[48] | si[48], last: olast_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_if.valid && iw.command == CmdSample) state_d = StRd;
      StRd:   state_d = StMul;
      StMul:  state_d = StAcc;
      StAcc: begin
        if (!last_beam) state_d = StRd;
        else if (last_ant) state_d = StERd;
        else state_d = StIdle;
      end
      StERd:  state_d = StEMul;
      StEMul: state_d = StOut;
      StOut: begin
        if (out_if.ready) state_d = last_beam ? StIdle : StERd;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      num_chan_q <= 5'd1; num_pol_q <= 2'd1; num_ant_q <= 5'd1; num_beam_q <= 4'd1;
      gain_q <= 16'd1; shift_q <= 5'd0;
      chan_q <= '0; pol_q <= '0; ant_q <= '0; beam_q <= '0;
      first_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          RegNumChan: num_chan_q <= cfg_if.data.data[4:0];
          RegNumPol:  num_pol_q  <= cfg_if.data.data[1:0];
          RegNumAnt:  num_ant_q  <= cfg_if.data.data[4:0];
          RegNumBeam: num_beam_q <= cfg_if.data.data[3:0];
          RegGainMan: gain_q     <= cfg_if.data.data;
          RegGainSh:  shift_q    <= cfg_if.data.data[4:0];
          default: ;
        endcase
        if (cfg_if.data.index == RegNumChan || cfg_if.data.index == RegNumPol
            || cfg_if.data.index == RegNumAnt || cfg_if.data.index == RegNumBeam) begin
          chan_q <= '0; pol_q <= '0; ant_q <= '0; first_q <= 1'b1;
        end
      end
      case (state_q)
        StIdle: beam_q <= '0;
        StAcc: begin
          if (!last_beam) beam_q <= beam_q + 1'b1;
          else begin
            beam_q <= '0;
            if (last_ant) begin
              first_q <= 1'b1;
            end else begin
              ant_q <= ant_q + 1'b1;
              first_q <= 1'b0;
            end
          end
        end
        StOut: if (out_if.ready) begin
          if (!last_beam) beam_q <= beam_q + 1'b1;
          else begin
            beam_q <= '0;
            ant_q <= '0;
            if (11'(pol_q) + 11'd1 >= np) begin
              pol_q <= '0;
              chan_q <= (11'(chan_q) + 11'd1 >= nc) ? '0 : chan_q + 1'b1;
            end else begin
              pol_q <= pol_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      xr_q <= iw.sample_real;
      xi_q <= iw.sample_imag;
    end
    if (state_q == StMul) begin
      p_rr_q <= xr_q * $signed(wrd[31:16]);
      p_ii_q <= xi_q * $signed(wrd[15:0]);
      p_ri_q <= xr_q * $signed(wrd[15:0]);
      p_ir_q <= xi_q * $signed(wrd[31:16]);
    end
    if (state_q == StEMul) begin
      gr_q <= 56'($signed(acc_rd[79:40])) * $signed({1'b0, gain_q});
      gi_q <= 56'($signed(acc_rd[39:0])) * $signed({1'b0, gain_q});
    end
    if (state_q == StEMul) begin
      och_q   <= 4'(chan_q);
      opol_q  <= 1'(pol_q);
      obeam_q <= 3'(beam_q);
      olast_q <= last_beam;
    end
  end
endmodule

/* src/cwb_checker.sv */
// port-level checks for the beamformer, bound to the top level
module cwb_checker
  import cwb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready,
  input out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped while stalled");
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready |-> in_ready)
    else $error("config open while busy");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("input word withdrawn before accept");
endmodule

bind complex_weighted_beamformer_unit cwb_checker u_cwb_checker (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .cfg_ready(cfg_if.ready), .out_data(out_if.data)
);

/* dv/tb_top.sv */
// self-checking testbench for the complex weighted beamformer unit
module tb_top;
  import cwb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegSpare = 3'd6;
  localparam int unsigned TblDepth = 4096;

  class beam_scoreboard;
    logic [15:0] w_re [TblDepth];
    logic [15:0] w_im [TblDepth];
    bit w_set [TblDepth];
    longint acc_re [8];
    longint acc_im [8];
    int unsigned chan_pos, pol_pos, ant_pos;
    int unsigned n_chan, n_pol, n_ant, n_beam, gain, shift;
    out_word_t beam_q[$];
    int unsigned mismatches, checked, samples, weights;

    function new();
      n_chan = 1; n_pol = 1; n_ant = 1; n_beam = 1; gain = 1; shift = 0;
      clear_group();
    endfunction

    function void clear_group();
      foreach (acc_re[b]) begin
        acc_re[b] = 0;
        acc_im[b] = 0;
      end
      chan_pos = 0; pol_pos = 0; ant_pos = 0;
    endfunction

    function int unsigned clip_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (reg_idx_e'(idx))
        RegNumChan: begin n_chan = d[4:0]; clear_group(); end
        RegNumPol:  begin n_pol = d[1:0]; clear_group(); end
        RegNumAnt:  begin n_ant = d[4:0]; clear_group(); end
        RegNumBeam: begin n_beam = d[3:0]; clear_group(); end
        RegGainMan: gain = d;
        RegGainSh:  shift = d[4:0];
        default: ;
      endcase
    endfunction

    function logic signed [47:0] scale_part(longint s, inout bit sat);
      longint r;
      longint hi;
      hi = (longint'(1) <<< 47) - 1;
      r = (s * longint'(gain)) >>> shift;
      if (r > hi) begin r = hi; sat = 1; end
      if (r < -hi - 1) begin r = -hi - 1; sat = 1; end
      return r[47:0];
    endfunction

    function void note_word(in_word_t w);
      int unsigned nb, addr;
      longint xr, xi, wr, wi;
      out_word_t o;
      bit sat;
      if (cmd_e'(w.command) == CmdWeight) begin
        addr = ((w.weight_chan * 2 + w.weight_pol) * 16 + w.weight_ant) * 8 + w.weight_beam;
        w_re[addr] = w.weight_real;
        w_im[addr] = w.weight_imag;
        w_set[addr] = 1'b1;
        weights++;
        return;
      end
      samples++;
      nb = clip_dim(n_beam, 8);
      xr = w.sample_real;
      xi = w.sample_imag;
      for (int b = 0; b < nb; b++) begin
        addr = ((chan_pos * 2 + pol_pos) * 16 + ant_pos) * 8 + b;
        wr = $signed(w_re[addr]);
        wi = $signed(w_im[addr]);
        acc_re[b] += xr * wr - xi * wi;
        acc_im[b] += xr * wi + xi * wr;
      end
      if (ant_pos + 1 >= clip_dim(n_ant, 16)) begin
        for (int b = 0; b < nb; b++) begin
          sat = 0;
          o.beam_real = scale_part(acc_re[b], sat);
          o.beam_imag = scale_part(acc_im[b], sat);
          o.out_chan = chan_pos[3:0];
          o.out_pol = pol_pos[0];
          o.out_beam = b[2:0];
          o.saturated = sat;
          o.last = (b + 1 == nb);
          beam_q = {beam_q, o};
          acc_re[b] = 0;
          acc_im[b] = 0;
        end
        ant_pos = 0;
        if (pol_pos + 1 >= clip_dim(n_pol, 2)) begin
          pol_pos = 0;
          chan_pos = (chan_pos + 1 >= clip_dim(n_chan, 16)) ? 0 : chan_pos + 1;
        end else begin
          pol_pos++;
        end
      end else begin
        ant_pos++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (beam_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected beam word chan %0d pol %0d beam %0d",
                   got.out_chan, got.out_pol, got.out_beam);
        return;
      end
      exp_w = beam_q.pop_front();
      checked++;
      if (got.beam_real !== exp_w.beam_real || got.beam_imag !== exp_w.beam_imag ||
          got.out_chan !== exp_w.out_chan || got.out_pol !== exp_w.out_pol ||
          got.out_beam !== exp_w.out_beam || got.saturated !== exp_w.saturated ||
          got.last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: beam word mismatch");
          $display("  exp re %0d im %0d c %0d p %0d b %0d s %0d l %0d",
                   exp_w.beam_real, exp_w.beam_imag, exp_w.out_chan, exp_w.out_pol,
                   exp_w.out_beam, exp_w.saturated, exp_w.last);
          $display("  got re %0d im %0d c %0d p %0d b %0d s %0d l %0d",
                   got.beam_real, got.beam_imag, got.out_chan, got.out_pol,
                   got.out_beam, got.saturated, got.last);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned tx_idle_pct, rx_idle_pct;
  beam_scoreboard sb;

  cwb_if #(.T(in_word_t))  in_if ();
  cwb_if #(.T(cfg_word_t)) cfg_if ();
  cwb_if #(.T(out_word_t)) out_if ();

  complex_weighted_beamformer_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .cfg_if(cfg_if.sink),
    .out_if(out_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_word(out_if.data);
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(w);
  endtask

  task automatic send_weight(int unsigned addr, logic [15:0] re, logic [15:0] im);
    in_word_t w;
    w = '0;
    // garbage sample fields are ignored on weight words
    w.sample_real = 16'($urandom);
    w.sample_imag = 16'($urandom);
    w.command = CmdWeight;
    {w.weight_chan, w.weight_pol, w.weight_ant, w.weight_beam} = addr[11:0];
    w.weight_real = re;
    w.weight_imag = im;
    send_word(w);
  endtask

  task automatic send_sample(logic [15:0] re, logic [15:0] im);
    in_word_t w;
    int unsigned base;
    base = ((sb.chan_pos * 2 + sb.pol_pos) * 16 + sb.ant_pos) * 8;
    // every weight this sample reads is written first
    for (int unsigned b = 0; b < sb.clip_dim(sb.n_beam, 8); b++)
      if (!sb.w_set[base + b]) send_weight(base + b, pick16(), pick16());
    w = '0;
    w.command = CmdSample;
    w.sample_real = re;
    w.sample_imag = im;
    send_word(w);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.beam_q.size() != 0) @(posedge clk_i);
    // a trailing sample or weight word may still be in flight with no result
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, data: d};
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, d);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [15:0] nc, np, na, nb, gm, gs);
    drain();
    write_cfg(RegNumChan, nc);
    write_cfg(RegNumPol, np);
    write_cfg(RegNumAnt, na);
    write_cfg(RegNumBeam, nb);
    write_cfg(RegGainMan, gm);
    write_cfg(RegGainSh, gs);
  endtask

  initial begin
    int unsigned n_items;
    sb = new();
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    tx_idle_pct = 37;
    rx_idle_pct = 46;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extreme weights on the first antenna of the first group
    for (int unsigned b = 0; b < 8; b++)
      send_weight(b, b[0] ? 16'h7fff : 16'h8000, b[1] ? 16'h7fff : 16'h8000);

    // zero geometry acts as one, zero gain, spare register index
    set_geometry(0, 0, 0, 0, 0, 0);
    write_cfg(RegSpare, 16'hffff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h7fff, 16'h7fff);

    // single antenna, all beams, full gain and widest shift
    set_geometry(1, 1, 1, 8, 16'hffff, 31);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'hffff, 16'h0001);

    // register values past the limits clamp; full gain saturates
    set_geometry(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
    for (int i = 0; i < 16; i++)
      send_sample(i[0] ? 16'h7fff : 16'h8000, i[1] ? 16'h7fff : 16'h8000);

    for (int ph = 0; ph < 9; ph++) begin
      tx_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 46 : 0;
      rx_idle_pct = (ph < 3) ? 46 : (ph < 6) ? 37 : 0;
      set_geometry(16'($urandom_range(1, 2)), 16'($urandom_range(1, 2)),
                   16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)),
                   (ph == 7) ? 16'hffff : 16'($urandom_range(1, 65535)),
                   (ph == 8) ? 16'd31 : 16'($urandom_range(0, 31)));
      n_items = $urandom_range(10, 16);
      for (int i = 0; i < n_items; i++) begin
        if (ph == 4 && i == n_items / 2) begin
          // hold off the sender until all beam words are out
          in_if.valid <= 1'b0;
          while (sb.beam_q.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(99) < 15) send_weight($urandom_range(TblDepth - 1), pick16(), pick16());
        else send_sample(pick16(), pick16());
      end
    end

    drain();
    $display("covered %0d samples, %0d weight writes, %0d beam words checked",
             sb.samples, sb.weights, sb.checked);
    $display("geometry from clamped extremes to single antenna, gain zero to full, shifts 0..31");
    if (sb.mismatches == 0 && sb.beam_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("mismatches: %0d, words left: %0d", sb.mismatches, sb.beam_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
